// ----- hdl/ssf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssf_pkg: shared constants for the source component finder
// Field widths, stream packing positions and input function codes.
// ----------------------------------------------------------------------------
package ssf_pkg;

	// Largest graph the block is built for by default.
	localparam int unsigned DEF_MAX_VERTICES = 64;

	// Field widths fixed by the interface.
	localparam int unsigned ROW_INDEX_W  = 6;
	localparam int unsigned ROW_W        = 64;
	localparam int unsigned SET_W        = 64;
	localparam int unsigned VERTEX_W     = 6;
	localparam int unsigned VCOUNT_W     = 7;

	// Input stream: row_index, adjacency_row, argument_set (lowest first).
	localparam int unsigned S_ROW_IDX_LSB = 0;
	localparam int unsigned S_ROW_LSB     = S_ROW_IDX_LSB + ROW_INDEX_W;
	localparam int unsigned S_SET_LSB     = S_ROW_LSB + ROW_W;
	localparam int unsigned S_USED_W      = S_SET_LSB + SET_W;
	localparam int unsigned S_TDATA_W     = ((S_USED_W + 7) / 8) * 8;

	// Output stream: component_set, source_vertex (lowest first).
	localparam int unsigned M_USED_W      = SET_W + VERTEX_W;
	localparam int unsigned M_TDATA_W     = ((M_USED_W + 7) / 8) * 8;
	localparam int unsigned M_PAD_W       = M_TDATA_W - M_USED_W;

	// Function carried in s_tuser.
	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_START = 1'b1
	} func_t;

	// Vertex count after reset.
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(64);

endpackage : ssf_pkg
`default_nettype wire

// ----- hdl/source_scc_finder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_scc_finder_unit: source strongly connected component finder
// Holds a directed graph as an adjacency matrix and, for a vertex subset,
// finds a source strongly connected component with two depth-first walks.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// --------  ---------  -------------------------------------------------------
// s_*       in         tuser: func; tdata: row_index, adjacency_row,
//                      argument_set (lowest bits first)
// m_*       out        tuser: empty_subset; tdata: component_set, source_vertex
// cfg_*     in         cfg_wr_data: vertex_count, written when cfg_wr_en is high
//
// A load transfer writes one row of the adjacency memory.
// A start transfer runs on one shared scan engine: a row sweep over all n
// vertices for roots, then for every vertex popped from the walk stack a scan
// of n candidates, one per cycle, plus stack access, memory access and scan
// pipeline drain.
// The backward walk reads one adjacency row per scanned candidate through the
// single read port of the adjacency memory. The walk stack never overflows:
// a vertex is pushed only once per walk. Reset clears the control state and
// sets vertex_count to 64; the adjacency memory is not cleared, so the user
// must write rows before they are used; the block does not enforce this.
// Load transfers are taken while a result waits on m_*; a new start is taken
// only after the search ends, and the finished result waits until m_tready.
// ----------------------------------------------------------------------------
module source_scc_finder_unit #(
	parameter int unsigned MAX_VERTICES = ssf_pkg::DEF_MAX_VERTICES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input stream.
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [ssf_pkg::S_TDATA_W-1:0]  s_tdata,   // row_index, adjacency_row, argument_set
	input  wire logic                           s_tuser,   // func
	// Output stream.
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [ssf_pkg::M_TDATA_W-1:0]  m_tdata,   // component_set, source_vertex
	output      logic                           m_tuser,   // empty_subset
	// Configuration.
	input  wire logic                           cfg_wr_en,
	input  wire logic [ssf_pkg::VCOUNT_W-1:0]   cfg_wr_data
);

	import ssf_pkg::*;

	// Vertex index width and count width (the count can hold MAX_VERTICES itself).
	localparam int unsigned IW = $clog2(MAX_VERTICES);
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROOT,
		S_POP,
		S_POPWAIT,
		S_SCAN,
		S_DONE
	} state_t;

	// Control state.
	state_t                     state_q;
	logic [VCOUNT_W-1:0]        vcount_q;
	logic [CW-1:0]              n_q;
	logic [MAX_VERTICES-1:0]    subset_q;
	logic [MAX_VERTICES-1:0]    visited_q;
	logic [CW-1:0]              depth_q;
	logic [CW-1:0]              i_q;
	logic [CW-1:0]              j_q;
	logic [IW-1:0]              last_root_q;
	logic [IW-1:0]              v_q;
	logic                       backward_q;
	logic                       empty_q;
	logic                       chk_valid_s1;
	logic [IW-1:0]              chk_idx_s1;
	logic                       out_valid_q;
	logic [M_TDATA_W-1:0]       out_data_q;
	logic                       out_empty_q;

	// Memories.
	logic [MAX_VERTICES-1:0]    adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]    adj_rd_q;
	logic [IW-1:0]              stk_mem [MAX_VERTICES];
	logic [IW-1:0]              stk_rd_q;

	// Combinational control.
	logic                       in_xfer;
	func_t                      in_func;
	logic [ROW_INDEX_W-1:0]     in_row_idx;
	logic [ROW_W-1:0]           in_row;
	logic [SET_W-1:0]           in_set;
	logic [CW-1:0]              n_eff;
	logic [MAX_VERTICES-1:0]    subset_in;
	logic                       adj_wr_en;
	logic                       adj_rd_en;
	logic [IW-1:0]              adj_rd_addr;
	logic                       push_en;
	logic [IW-1:0]              push_idx;
	logic [MAX_VERTICES-1:0]    push_bit;
	logic                       root_cand;
	logic                       edge_hit;
	logic                       scan_issue;
	logic                       out_free;

	assign in_xfer    = s_tvalid && s_tready;
	assign in_func    = func_t'(s_tuser);
	assign in_row_idx = s_tdata[S_ROW_IDX_LSB +: ROW_INDEX_W];
	assign in_row     = s_tdata[S_ROW_LSB +: ROW_W];
	assign in_set     = s_tdata[S_SET_LSB +: SET_W];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_empty_q;
	assign out_free = !out_valid_q || m_tready;

	// Vertices in use, clipped to the size of the build.
	assign n_eff = (vcount_q > VCOUNT_W'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_q);

	// Subset bits at or beyond the vertex count are dropped.
	always_comb begin
		for (int k = 0; k < MAX_VERTICES; k++) begin
			subset_in[k] = in_set[k] && (CW'(k) < n_eff);
		end
	end

	// Rows aimed past the end of the memory are dropped.
	assign adj_wr_en = in_xfer && (in_func == FUNC_LOAD)
		&& ({1'b0, in_row_idx} < (ROW_INDEX_W + 1)'(MAX_VERTICES));

	// The scan issues one candidate per cycle until all n are issued.
	assign scan_issue = (state_q == S_SCAN) && (j_q != n_q);

	// Forward rows are read once per popped vertex; backward scans read the
	// candidate's own row and test the bit of the popped vertex.
	always_comb begin
		adj_rd_en   = 1'b0;
		adj_rd_addr = stk_rd_q;
		if (state_q == S_POPWAIT && !backward_q) begin
			adj_rd_en   = 1'b1;
			adj_rd_addr = stk_rd_q;
		end else if (scan_issue && backward_q) begin
			adj_rd_en   = 1'b1;
			adj_rd_addr = j_q[IW-1:0];
		end
	end

	assign root_cand = (i_q != n_q) && subset_q[i_q[IW-1:0]] && !visited_q[i_q[IW-1:0]];
	assign edge_hit  = backward_q ? adj_rd_q[v_q] : adj_rd_q[chk_idx_s1];

	// At most one push per cycle: a new root, the backward root, or a scan hit.
	always_comb begin
		push_en  = 1'b0;
		push_idx = i_q[IW-1:0];
		unique case (state_q)
			S_ROOT: begin
				if (i_q == n_q) begin
					push_en  = 1'b1;
					push_idx = last_root_q;
				end else begin
					push_en  = root_cand;
					push_idx = i_q[IW-1:0];
				end
			end
			S_SCAN: begin
				push_idx = chk_idx_s1;
				push_en  = chk_valid_s1 && subset_q[chk_idx_s1] && !visited_q[chk_idx_s1]
					&& edge_hit;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	assign push_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << push_idx;

	// Adjacency memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (adj_wr_en) begin
			adj_mem[in_row_idx[IW-1:0]] <= in_row[MAX_VERTICES-1:0];
		end
		if (adj_rd_en) begin
			adj_rd_q <= adj_mem[adj_rd_addr];
		end
	end

	// Walk stack memory: pushes write at the depth, pops read below it.
	always_ff @(posedge clk) begin
		if (push_en) begin
			stk_mem[depth_q[IW-1:0]] <= push_idx;
		end
		if (state_q == S_POP && depth_q != '0) begin
			stk_rd_q <= stk_mem[IW'(depth_q - CW'(1))];
		end
	end

	// Sequencer and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vcount_q     <= VCOUNT_RESET;
			n_q          <= '0;
			subset_q     <= '0;
			visited_q    <= '0;
			depth_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			last_root_q  <= '0;
			v_q          <= '0;
			backward_q   <= 1'b0;
			empty_q      <= 1'b0;
			chk_valid_s1 <= 1'b0;
			chk_idx_s1   <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_empty_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			// In S_DONE the output register is refilled below instead.
			if (out_valid_q && m_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && in_func == FUNC_START) begin
						n_q        <= n_eff;
						subset_q   <= subset_in;
						visited_q  <= '0;
						depth_q    <= '0;
						i_q        <= '0;
						backward_q <= 1'b0;
						if (subset_in == '0) begin
							// Nothing to search: report an empty subset.
							empty_q     <= 1'b1;
							last_root_q <= '0;
							state_q     <= S_DONE;
						end else begin
							empty_q <= 1'b0;
							state_q <= S_ROOT;
						end
					end
				end
				S_ROOT: begin
					if (i_q == n_q) begin
						// Forward walks done; restart from the last root backward.
						visited_q  <= push_bit;
						depth_q    <= depth_q + CW'(1);
						backward_q <= 1'b1;
						state_q    <= S_POP;
					end else begin
						i_q <= i_q + CW'(1);
						if (push_en) begin
							last_root_q <= i_q[IW-1:0];
							visited_q   <= visited_q | push_bit;
							depth_q     <= depth_q + CW'(1);
							state_q     <= S_POP;
						end
					end
				end
				S_POP: begin
					if (depth_q == '0) begin
						state_q <= backward_q ? S_DONE : S_ROOT;
					end else begin
						depth_q <= depth_q - CW'(1);
						state_q <= S_POPWAIT;
					end
				end
				S_POPWAIT: begin
					v_q          <= stk_rd_q;
					j_q          <= '0;
					chk_valid_s1 <= 1'b0;
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					chk_valid_s1 <= scan_issue;
					chk_idx_s1   <= j_q[IW-1:0];
					if (scan_issue) begin
						j_q <= j_q + CW'(1);
					end
					if (push_en) begin
						visited_q <= visited_q | push_bit;
						depth_q   <= depth_q + CW'(1);
					end
					if (!scan_issue && !chk_valid_s1) begin
						state_q <= S_POP;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {{M_PAD_W{1'b0}}, VERTEX_W'(last_root_q),
							SET_W'(visited_q)};
						out_empty_q <= empty_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule : source_scc_finder_unit
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for source_scc_finder_unit
// Loads adjacency rows and starts searches over vertex subsets on the input
// stream. Every result on the output stream is checked against a behavioral
// model of the two depth-first walks kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
	import ssf_pkg::*;

	localparam int unsigned CLK_PERIOD   = 8;
	localparam int unsigned GAP_PERCENT  = 18;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES  = 2000;
	localparam int unsigned DRAIN_LIMIT  = 40000;
	// The timeout leaves a wide margin over the length of the whole run.
	localparam longint      TIMEOUT_NS   = 64'd4_000_000 * CLK_PERIOD;
	localparam logic [63:0] ALL_ONES     = {64{1'b1}};
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned RANDOM_PHASE_ITEMS = 6;
	localparam int unsigned HOLD_STARTS  = 3;

	// One search result as it leaves the block.
	typedef struct packed {
		logic [SET_W-1:0]    comp;
		logic [VERTEX_W-1:0] src;
		logic                empty;
	} scc_result_t;

	// One row of the directed stimulus. When known is set, the result is
	// taken from the row instead of the search model.
	typedef struct packed {
		func_t                  fn;
		logic [ROW_INDEX_W-1:0] idx;
		logic [ROW_W-1:0]       row;
		logic [SET_W-1:0]       subset;
		logic                   known;
		scc_result_t            want;
	} stim_row_t;

	localparam int unsigned DIRECTED_ROWS = 19;

	// All rows hold no edges when this list begins, and 64 vertices are in use.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Empty subset raises the flag with a zero mask and a zero root.
		'{FUNC_START, 6'd0,  64'd0, 64'd0, 1'b1, '{64'd0, 6'd0, 1'b1}},
		// No edges: every vertex is its own root, the last one is 63.
		'{FUNC_START, 6'd0,  64'd0, ALL_ONES, 1'b1,
			'{64'h8000_0000_0000_0000, 6'd63, 1'b0}},
		// Vertex 0 alone.
		'{FUNC_START, 6'd0,  64'd0, 64'd1, 1'b1, '{64'd1, 6'd0, 1'b0}},
		// The two extreme vertices, no edge between them.
		'{FUNC_START, 6'd0,  64'd0, 64'h8000_0000_0000_0001, 1'b1,
			'{64'h8000_0000_0000_0000, 6'd63, 1'b0}},
		'{FUNC_LOAD,  6'd0,  ALL_ONES, 64'd0, 1'b0, '0},
		'{FUNC_START, 6'd0,  64'd0, ALL_ONES, 1'b0, '0},
		'{FUNC_LOAD,  6'd63, ALL_ONES, 64'd0, 1'b0, '0},
		'{FUNC_START, 6'd0,  64'd0, ALL_ONES, 1'b0, '0},
		'{FUNC_LOAD,  6'd0,  64'd0, ALL_ONES, 1'b0, '0},
		'{FUNC_START, 6'd63, ALL_ONES, ALL_ONES, 1'b0, '0},
		'{FUNC_LOAD,  6'd1,  64'h5, 64'd0, 1'b0, '0},
		'{FUNC_LOAD,  6'd2,  64'h2, 64'd0, 1'b0, '0},
		'{FUNC_START, 6'd0,  64'd0, 64'h7, 1'b0, '0},
		'{FUNC_LOAD,  6'd62, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 1'b0, '0},
		'{FUNC_LOAD,  6'd31, 64'h5555_5555_5555_5555, 64'd0, 1'b0, '0},
		'{FUNC_START, 6'd0,  64'd0, 64'hFFFF_FFFF_0000_0000, 1'b0, '0},
		'{FUNC_START, 6'd0,  64'd0, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '0},
		'{FUNC_LOAD,  6'd63, 64'd0, ALL_ONES, 1'b0, '0},
		'{FUNC_START, 6'd0,  64'd0, 64'hC000_0000_8000_0006, 1'b0, '0}
	};

	// Vertex count settings walked after the directed part, with item counts.
	localparam int unsigned FIXED_PHASES = 6;
	localparam logic [VCOUNT_W-1:0] PHASE_VCOUNT [FIXED_PHASES] =
		'{7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd64};
	localparam int unsigned PHASE_ITEMS [FIXED_PHASES] = '{5, 3, 3, 6, 3, 3};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tuser;
	logic                   cfg_wr_en;
	logic [VCOUNT_W-1:0]    cfg_wr_data;

	// Shadow of the block state that decides the results.
	logic [ROW_W-1:0]       adj_model [DEF_MAX_VERTICES];
	logic [VCOUNT_W-1:0]    vcount_model = VCOUNT_RESET;

	scc_result_t            pending_results [$];
	int unsigned            fail_count = 0;
	bit                     gaps_on = 1'b1;
	bit                     hold_request = 1'b0;
	int unsigned            hold_left = 0;

	source_scc_finder_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	// Depth-first walk from root inside subset. Vertices already in seen_in are
	// not entered again. A backward walk follows the edges in reverse.
	function automatic logic [SET_W-1:0] trace_reach(input int unsigned root,
			input logic [SET_W-1:0] subset, input int unsigned n, input bit backward,
			input logic [SET_W-1:0] seen_in);
		logic [SET_W-1:0] seen;
		int unsigned      stack [DEF_MAX_VERTICES];
		int unsigned      depth;
		int unsigned      v;
		bit               hop;
		seen = seen_in;
		seen[root] = 1'b1;
		stack[0] = root;
		depth = 1;
		while (depth > 0) begin
			depth--;
			v = stack[depth];
			for (int unsigned j = 0; j < n; j++) begin
				if (subset[j] && !seen[j]) begin
					hop = backward ? adj_model[j][v] : adj_model[v][j];
					if (hop) begin
						seen[j] = 1'b1;
						stack[depth] = j;
						depth++;
					end
				end
			end
		end
		return seen;
	endfunction

	// Source component of the subgraph induced by the subset, as the block
	// should report it for the current vertex count.
	function automatic scc_result_t predict_source(input logic [SET_W-1:0] arg);
		scc_result_t      res;
		int unsigned      n;
		int unsigned      root;
		logic [SET_W-1:0] subset;
		logic [SET_W-1:0] seen;
		n = (vcount_model > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : vcount_model;
		subset = (n >= 64) ? arg : (arg & ((64'd1 << n) - 64'd1));
		res = '0;
		if (subset == '0) begin
			res.empty = 1'b1;
			return res;
		end
		seen = '0;
		root = 0;
		for (int unsigned i = 0; i < n; i++) begin
			if (subset[i] && !seen[i]) begin
				root = i;
				seen = trace_reach(i, subset, n, 1'b0, seen);
			end
		end
		res.comp = trace_reach(root, subset, n, 1'b1, '0);
		res.src = VERTEX_W'(root);
		return res;
	endfunction

	// Offers one item and waits for its transfer. The state shadow and the
	// queue of expected results are updated at the edge of the transfer.
	task automatic send_item(input func_t fn, input logic [ROW_INDEX_W-1:0] idx,
			input logic [ROW_W-1:0] row, input logic [SET_W-1:0] subset,
			input logic known, input scc_result_t want);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[S_ROW_IDX_LSB +: ROW_INDEX_W] = idx;
		word[S_ROW_LSB +: ROW_W] = row;
		word[S_SET_LSB +: SET_W] = subset;
		while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (fn == FUNC_LOAD)
			adj_model[idx] = row;
		else
			pending_results.push_back(known ? want : predict_source(subset));
	endtask

	// Stops offering and waits until every expected result has arrived and a
	// trailing load has surely been written.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		vcount_model = value;
	endtask

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Rows lean toward sparse graphs so that the walks find real components.
	function automatic logic [ROW_W-1:0] random_row(input int unsigned n);
		int unsigned pick;
		pick = $urandom_range(9);
		case (pick)
			0: return '0;
			1: return ALL_ONES;
			2, 3: return random_word();
			4, 5, 6: return random_word() & random_word() & random_word();
			default: return 64'd1 << $urandom_range((n > 0) ? n - 1 : 63);
		endcase
	endfunction

	function automatic logic [SET_W-1:0] random_subset(input int unsigned n);
		int unsigned pick;
		int unsigned lo;
		int unsigned hi;
		pick = $urandom_range(19);
		lo = $urandom_range(63);
		hi = $urandom_range(63);
		if (lo > hi) begin
			lo = lo ^ hi;
			hi = lo ^ hi;
			lo = lo ^ hi;
		end
		case (pick)
			0: return '0;
			1, 2, 3, 4: return ALL_ONES;
			5, 6: return 64'd1 << $urandom_range((n > 0) ? n - 1 : 63);
			7, 8, 9: return (ALL_ONES >> (63 - hi)) & (ALL_ONES << lo);
			10, 11, 12: return random_word() & random_word();
			default: return random_word();
		endcase
	endfunction

	// Mostly loads of rows in use and starts; some loads land on unused rows.
	task automatic random_item(input int unsigned n);
		logic [ROW_INDEX_W-1:0] idx;
		if ($urandom_range(99) < 45) begin
			send_item(FUNC_START, ROW_INDEX_W'($urandom), random_word(),
				random_subset(n), 1'b0, '0);
		end else begin
			if (n > 0 && $urandom_range(99) < 85)
				idx = ROW_INDEX_W'($urandom_range((n > 64 ? 64 : n) - 1));
			else
				idx = ROW_INDEX_W'($urandom_range(63));
			send_item(FUNC_LOAD, idx, random_row(n), random_word(), 1'b0, '0);
		end
	endtask

	// Receiver: checks each result transfer and drives m_tready. A hold request
	// from the stimulus keeps m_tready low for a long stretch so that the block
	// fills up and pushes back on its input.
	initial begin : result_sink
		scc_result_t          want;
		logic [SET_W-1:0]     got_comp;
		logic [VERTEX_W-1:0]  got_src;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got_comp = m_tdata[0 +: SET_W];
				got_src = m_tdata[SET_W +: VERTEX_W];
				if (pending_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with none expected: component_set %h "
						, $time, got_comp, "source_vertex %0d empty_subset %b",
						got_src, m_tuser);
				end else begin
					want = pending_results.pop_front();
					if (got_comp !== want.comp) begin
						fail_count++;
						$display("%0t: component_set expected %h actual %h",
							$time, want.comp, got_comp);
					end
					if (got_src !== want.src) begin
						fail_count++;
						$display("%0t: source_vertex expected %0d actual %0d",
							$time, want.src, got_src);
					end
					if (m_tuser !== want.empty) begin
						fail_count++;
						$display("%0t: empty_subset expected %b actual %b",
							$time, want.empty, m_tuser);
					end
				end
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
			end
		end
	end

	initial begin : stimulus
		int unsigned n;
		int unsigned waited;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= FUNC_LOAD;
		s_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every row is written once before any search may read it.
		for (int i = 0; i < DEF_MAX_VERTICES; i++)
			send_item(FUNC_LOAD, ROW_INDEX_W'(i), '0, random_word(), 1'b0, '0);

		// Directed part at the reset vertex count of 64.
		for (int k = 0; k < DIRECTED_ROWS; k++)
			send_item(DIRECTED[k].fn, DIRECTED[k].idx, DIRECTED[k].row,
				DIRECTED[k].subset, DIRECTED[k].known, DIRECTED[k].want);

		// Fixed settings: one vertex, none at all, counts past the maximum that
		// clamp to 64, two vertices, and 64 written explicitly.
		for (int p = 0; p < FIXED_PHASES; p++) begin
			write_vertex_count(PHASE_VCOUNT[p]);
			for (int i = 0; i < PHASE_ITEMS[p]; i++)
				random_item(PHASE_VCOUNT[p]);
		end

		// Small random graphs of 3 to 16 vertices follow. The first phase stalls
		// the receiver for a long stretch and opens with three starts: one
		// result waits at the output, the next waits in the block, and the
		// third is held off at the input. A later phase runs without gaps.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			n = $urandom_range(3, 16);
			write_vertex_count(VCOUNT_W'(n));
			if (p == 0)
				hold_request = 1'b1;
			gaps_on = (p != 4);
			for (int i = 0; i < RANDOM_PHASE_ITEMS; i++) begin
				if (p == 0 && i < HOLD_STARTS)
					send_item(FUNC_START, '0, '0, random_subset(n), 1'b0, '0);
				else
					random_item(n);
			end
		end
		gaps_on = 1'b1;

		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d expected results never arrived", $time,
				pending_results.size());
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
